// ===== rtl/memory_region_key_table_defines.svh =====
// Assertion macros for the memory region key table.
`ifndef MEMORY_REGION_KEY_TABLE_DEFINES_SVH
`define MEMORY_REGION_KEY_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define MRKT_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define MRKT_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`else
`define MRKT_ASSERT_IMP(label, clk, rst, a, c)
`define MRKT_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// ===== rtl/mrkt_pkg.sv =====
// Package: types, codes and sizes of the memory region key table.
package mrkt_pkg;
   localparam int MaxMrs = 64;
   localparam int SlotW = $clog2(MaxMrs);
   localparam int CountW = $clog2(MaxMrs + 1);
   localparam logic [31:0] KeyStart = 32'h100;

   localparam logic [2:0] ACT_REGISTER = 3'd0;
   localparam logic [2:0] ACT_DEREGISTER = 3'd1;
   localparam logic [2:0] ACT_LOCAL = 3'd2;
   localparam logic [2:0] ACT_REMOTE = 3'd3;
   localparam logic [2:0] ACT_CLEAR = 3'd4;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_FULL = 3'd1;
   localparam logic [2:0] ST_ZERO_LEN = 3'd2;
   localparam logic [2:0] ST_UNKNOWN = 3'd3;
   localparam logic [2:0] ST_DOMAIN = 3'd4;
   localparam logic [2:0] ST_BOUNDS = 3'd5;
   localparam logic [2:0] ST_PERM = 3'd6;

   typedef struct packed {
      logic [2:0] action;
      logic [31:0] key;
      logic [31:0] domain;
      logic [63:0] address;
      logic [63:0] length;
      logic write_access;
      logic [3:0] perms;
   } req_type;

   typedef struct packed {
      logic ok;
      logic [2:0] status;
      logic [31:0] local_key;
      logic [31:0] remote_key;
   } rsp_type;

   // Classified word passed from the front to the back.
   typedef struct packed {
      req_type req;
      logic hit;
      logic [SlotW-1:0] slot;
   } work_type;
endpackage

// ===== rtl/mrkt_front.sv =====
// Front: accepts requests and searches the key columns for a matching slot.
module mrkt_front import mrkt_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input req_type req_word,
   input logic [MaxMrs-1:0] valid_vec,
   input logic [MaxMrs-1:0][31:0] lkey_vec,
   input logic [MaxMrs-1:0][31:0] rkey_vec,
   input logic busy,
   output logic [SlotW-1:0] look_slot,
   output logic work_valid,
   output work_type work_word
);
   logic take;
   logic [MaxMrs-1:0] match;
   logic hit;
   logic [SlotW-1:0] slot;
   logic work_valid_ff, work_valid_in;
   work_type work_ff, work_in;

   // One item in flight: hold until the back has retired it.
   assign req_stall = work_valid_ff | busy;
   assign take = req_valid & ~req_stall;

   always_comb begin
      for (int i = 0; i < MaxMrs; i++) begin
         match[i] = valid_vec[i] & ((req_word.action == ACT_REMOTE) ?
            (rkey_vec[i] == req_word.key) : (lkey_vec[i] == req_word.key));
      end
      hit = |match;
      slot = '0;
      for (int i = MaxMrs - 1; i >= 0; i--) begin
         if (match[i]) begin
            slot = SlotW'(i);
         end
      end
   end

   // The back reads the region fields at this slot on the accepting edge.
   assign look_slot = slot;

   always_comb begin
      work_valid_in = take;
      work_in = work_ff;
      if (take) begin
         work_in.req = req_word;
         work_in.hit = hit;
         work_in.slot = slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
      end
      work_ff <= work_in;
   end

   assign work_valid = work_valid_ff;
   assign work_word = work_ff;
endmodule

// ===== rtl/mrkt_back.sv =====
// Back: applies a classified request to the table and forms the response.
module mrkt_back import mrkt_pkg::*; (
   input logic clock,
   input logic reset,
   input logic [6:0] max_regions,
   input logic [SlotW-1:0] look_slot,
   input logic work_valid,
   input work_type work_word,
   output logic busy,
   output logic [MaxMrs-1:0] valid_vec,
   output logic [MaxMrs-1:0][31:0] lkey_vec,
   output logic [MaxMrs-1:0][31:0] rkey_vec,
   output logic rsp_valid,
   input logic rsp_stall,
   output rsp_type rsp_word
);
   logic [MaxMrs-1:0] valid_ff, valid_in;
   logic [MaxMrs-1:0][31:0] lkey_ff, rkey_ff;
   logic [63:0] base_mem [MaxMrs];
   logic [63:0] len_mem [MaxMrs];
   logic [31:0] dom_mem [MaxMrs];
   logic [3:0] perm_mem [MaxMrs];
   logic [CountW-1:0] count_ff, count_in;
   logic [31:0] key_ff, key_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic [6:0] limit;
   logic [SlotW-1:0] free_slot;
   logic free_any;
   logic do_reg;
   logic [63:0] e_base_ff, e_len_ff;
   logic [31:0] e_dom_ff;
   logic [3:0] e_perm_ff;
   logic [63:0] e_base, e_len, off;
   logic [31:0] e_dom;
   logic [3:0] e_perm;
   logic [1:0] bitsel;
   req_type r;

   assign r = work_word.req;
   assign limit = (max_regions > 7'(MaxMrs)) ? 7'(MaxMrs) : max_regions;
   assign busy = rsp_valid_ff;
   assign valid_vec = valid_ff;
   assign lkey_vec = lkey_ff;
   assign rkey_vec = rkey_ff;
   assign e_base = e_base_ff;
   assign e_len = e_len_ff;
   assign e_dom = e_dom_ff;
   assign e_perm = e_perm_ff;
   assign off = r.address - e_base;
   assign bitsel = {r.action == ACT_REMOTE, r.write_access};

   always_comb begin
      free_any = ~&valid_ff;
      free_slot = '0;
      for (int i = MaxMrs - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_slot = SlotW'(i);
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      key_in = key_ff;
      rsp_in = rsp_ff;
      do_reg = 1'b0;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (work_valid) begin
         rsp_valid_in = 1'b1;
         rsp_in = '0;
         case (r.action)
            ACT_REGISTER: begin
               if ((7'(count_ff) >= limit) || !free_any) begin
                  rsp_in.status = ST_FULL;
               end else if (r.length == 64'd0) begin
                  rsp_in.status = ST_ZERO_LEN;
               end else begin
                  do_reg = 1'b1;
                  valid_in[free_slot] = 1'b1;
                  count_in = count_ff + 1'b1;
                  key_in = key_ff + 32'd2;
                  rsp_in.ok = 1'b1;
                  rsp_in.local_key = key_ff;
                  rsp_in.remote_key = key_ff + 32'd1;
               end
            end
            ACT_DEREGISTER: begin
               if (!work_word.hit) begin
                  rsp_in.status = ST_UNKNOWN;
               end else begin
                  valid_in[work_word.slot] = 1'b0;
                  if (count_ff != '0) begin
                     count_in = count_ff - 1'b1;
                  end
                  rsp_in.ok = 1'b1;
               end
            end
            ACT_LOCAL, ACT_REMOTE: begin
               if (!work_word.hit) begin
                  rsp_in.status = ST_UNKNOWN;
               end else if (r.action == ACT_REMOTE && e_dom != r.domain) begin
                  rsp_in.status = ST_DOMAIN;
               end else if (r.address < e_base || r.length > e_len ||
                            off > e_len - r.length) begin
                  rsp_in.status = ST_BOUNDS;
               end else if (!e_perm[bitsel]) begin
                  rsp_in.status = ST_PERM;
               end
               rsp_in.ok = (rsp_in.status == ST_OK);
            end
            ACT_CLEAR: begin
               valid_in = '0;
               count_in = '0;
               key_in = KeyStart;
               rsp_in.ok = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         key_ff <= KeyStart;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         key_ff <= key_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
      // Registered read: the slot found at acceptance is used in the following cycle, with the work word.
      e_base_ff <= base_mem[look_slot];
      e_len_ff <= len_mem[look_slot];
      e_dom_ff <= dom_mem[look_slot];
      e_perm_ff <= perm_mem[look_slot];
      if (do_reg) begin
         lkey_ff[free_slot] <= key_ff;
         rkey_ff[free_slot] <= key_ff + 32'd1;
         base_mem[free_slot] <= r.address;
         len_mem[free_slot] <= r.length;
         dom_mem[free_slot] <= r.domain;
         perm_mem[free_slot] <= r.perms;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_ff;
endmodule

// ===== rtl/memory_region_key_table.sv =====
// Top level: memory region key table with front search and back update.
// The accepted request word is registered in the front, then the response word in the back.
// A new request is taken only once the previous one is through: the front holds one word
// in flight and waits for the response word to drain.
// Reset: synchronous, clears valid bits, region count, key counter 0x100,
// and sets max_regions to 64; stored region fields are not cleared.
`include "memory_region_key_table_defines.svh"
module memory_region_key_table import mrkt_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input req_type req_word,
   output logic rsp_valid,
   input logic rsp_stall,
   output rsp_type rsp_word,
   input logic csr_valid,
   output logic csr_ready,
   input logic [6:0] csr_data
);
   logic [6:0] max_regions_ff;
   logic busy;
   logic work_valid;
   work_type work_word;
   logic [SlotW-1:0] look_slot;
   logic [MaxMrs-1:0] valid_vec;
   logic [MaxMrs-1:0][31:0] lkey_vec, rkey_vec;

   // The register is always writable.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_regions_ff <= 7'd64;
      end else if (csr_valid) begin
         max_regions_ff <= csr_data;
      end
   end

   // Front: take the word and resolve the key to a slot.
   mrkt_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_word,
      .valid_vec, .lkey_vec, .rkey_vec, .busy, .look_slot,
      .work_valid, .work_word
   );

   // Back: read the region at the found slot, update the table and hold the response word.
   mrkt_back u_back (
      .clock, .reset, .max_regions(max_regions_ff), .look_slot,
      .work_valid, .work_word, .busy,
      .valid_vec, .lkey_vec, .rkey_vec,
      .rsp_valid, .rsp_stall, .rsp_word
   );

   `MRKT_ASSERT_NEXT(a_accept_to_work, clock, reset, req_valid && !req_stall, work_valid)
   `MRKT_ASSERT_IMP(a_no_take_busy, clock, reset, work_valid, req_stall)
   `MRKT_ASSERT_IMP(a_keys_only_ok, clock, reset, rsp_valid && !rsp_word.ok, rsp_word.local_key == 32'd0)
endmodule
